### design/resource_region_registry_top_defines.svh
// assertion macros for the resource region registry checker
`ifndef RESOURCE_REGION_REGISTRY_TOP_DEFINES_SVH
`define RESOURCE_REGION_REGISTRY_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("registry port check failed");

// next-cycle implication, disabled while in reset
`define RRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("registry port check failed");

`endif

### design/rrr_pkg.sv
// shared types, codes and sizes for the resource region registry
package rrr_pkg;

  localparam int OWNER_SLOTS  = 16;
  localparam int REGION_SLOTS = 32;

  localparam int OWN_IDX_W = $clog2(OWNER_SLOTS);
  localparam int OWN_CNT_W = $clog2(OWNER_SLOTS + 1);
  localparam int REG_IDX_W = $clog2(REGION_SLOTS);
  localparam int REG_CNT_W = $clog2(REGION_SLOTS + 1);
  localparam int SLOT_W    = 5;

  typedef enum logic [2:0] {
    OP_ADD_OWNER         = 3'd0,
    OP_ADD_REGION        = 3'd1,
    OP_DEL_OWNER         = 3'd2,
    OP_DEL_OWNER_REGIONS = 3'd3,
    OP_DEL_REGION        = 3'd4,
    OP_FIND              = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_HANDLE = 3'd2,
    ST_FREE       = 3'd3,
    ST_ZERO_ADDR  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  owner_id;
    logic [4:0]  region_id;
    logic [63:0] address;
    logic [39:0] region_size;
    logic [31:0] region_type;
    logic [63:0] user_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic        found;
    logic [4:0]  hit_slot;
    logic [3:0]  hit_owner;
    logic [63:0] hit_base;
    logic [39:0] hit_size;
    logic [31:0] hit_type;
    logic [63:0] hit_user;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  owner;
    logic [63:0] base;
    logic [39:0] size;
    logic [31:0] kind;
    logic [63:0] user;
  } region_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_needed;
    logic scan_end;
  } dp_sts_t;

endpackage

### design/rrr_ctrl.sv
// sequencing state machine for the resource region registry
module rrr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rrr_pkg::dp_sts_t sts,
  output rrr_pkg::dp_cmd_t cmd,
  output logic            busy,
  output logic            out_valid
);
  import rrr_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.scan_needed) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        // result shows this cycle; a new item may already be taken
        busy      = 1'b0;
        out_valid = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### design/rrr_dpath.sv
// tables, slot picking and region scan datapath for the registry
module rrr_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  rrr_pkg::in_item_t  in_item,
  input  rrr_pkg::dp_cmd_t   cmd,
  output rrr_pkg::dp_sts_t   sts,
  output rrr_pkg::out_item_t out_item
);
  import rrr_pkg::*;

  in_item_t               item_r;
  logic [OWNER_SLOTS-1:0]  owner_live_r;
  logic [OWN_CNT_W-1:0]    owner_hw_r;
  logic [REGION_SLOTS-1:0] region_live_r;
  logic [REG_CNT_W-1:0]    region_hw_r;
  logic [REG_CNT_W-1:0]    idx_r;
  logic                    rd_valid_r;
  logic [REG_IDX_W-1:0]    rd_idx_r;
  logic                    found_r;
  out_item_t               res_r;

  region_entry_t           mem [REGION_SLOTS];
  region_entry_t           mem_q;

  logic [OWN_IDX_W-1:0]    own_pick;
  logic                    own_pick_ok;
  logic [REG_IDX_W-1:0]    reg_pick;
  logic                    reg_pick_ok;
  logic                    oid_ok;
  logic                    rid_ok;
  logic                    is_find;
  logic [63:0]             region_end;
  logic                    in_range;
  logic                    hit_now;
  logic                    owner_match;
  logic                    issue;
  logic                    add_region_ok;
  region_entry_t           new_entry;
  out_item_t               exec_res;

  // lowest free slot; slots at or above the high-water count are never live,
  // so the lowest clear bit is either a hole or the append position
  always_comb begin
    own_pick    = '0;
    own_pick_ok = 1'b0;
    for (int i = OWNER_SLOTS - 1; i >= 0; i--) begin
      if (!owner_live_r[i]) begin
        own_pick    = OWN_IDX_W'(i);
        own_pick_ok = 1'b1;
      end
    end
  end

  always_comb begin
    reg_pick    = '0;
    reg_pick_ok = 1'b0;
    for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
      if (!region_live_r[i]) begin
        reg_pick    = REG_IDX_W'(i);
        reg_pick_ok = 1'b1;
      end
    end
  end

  assign oid_ok  = OWN_CNT_W'(item_r.owner_id) < owner_hw_r;
  assign rid_ok  = REG_CNT_W'(item_r.region_id) < region_hw_r;
  assign is_find = item_r.op == OP_FIND;

  assign add_region_ok = oid_ok && (item_r.address != 64'd0) && reg_pick_ok;

  always_comb begin
    new_entry.owner = item_r.owner_id;
    new_entry.base  = item_r.address;
    new_entry.size  = item_r.region_size;
    new_entry.kind  = item_r.region_type;
    new_entry.user  = item_r.user_word;
  end

  // operations that need no region scan
  always_comb begin
    exec_res = '0;
    case (item_r.op)
      OP_ADD_OWNER: begin
        if (own_pick_ok) begin
          exec_res.slot = SLOT_W'(own_pick);
        end else begin
          exec_res.status = ST_FULL;
        end
      end
      OP_ADD_REGION: begin
        if (!oid_ok) begin
          exec_res.status = ST_BAD_HANDLE;
        end else if (item_r.address == 64'd0) begin
          exec_res.status = ST_ZERO_ADDR;
        end else if (!reg_pick_ok) begin
          exec_res.status = ST_FULL;
        end else begin
          exec_res.slot = SLOT_W'(reg_pick);
        end
      end
      OP_DEL_OWNER, OP_DEL_OWNER_REGIONS: begin
        exec_res.status = ST_BAD_HANDLE;
      end
      OP_DEL_REGION: begin
        if (!rid_ok) begin
          exec_res.status = ST_BAD_HANDLE;
        end else if (!region_live_r[item_r.region_id]) begin
          exec_res.status = ST_FREE;
        end
      end
      default: begin
        exec_res = '0;
      end
    endcase
  end

  // scan pipeline: read at idx_r, evaluate registered entry at rd_idx_r
  assign region_end  = mem_q.base + 64'(mem_q.size);
  assign in_range    = (item_r.address >= mem_q.base) && (item_r.address < region_end);
  assign hit_now     = rd_valid_r && is_find && !found_r &&
                       region_live_r[rd_idx_r] && in_range;
  assign owner_match = rd_valid_r && !is_find && region_live_r[rd_idx_r] &&
                       (mem_q.owner == item_r.owner_id);
  assign issue       = cmd.scan_step && (idx_r < region_hw_r) && !found_r && !hit_now;

  always_comb begin
    sts.scan_needed = is_find ||
                      (((item_r.op == OP_DEL_OWNER) ||
                        (item_r.op == OP_DEL_OWNER_REGIONS)) && oid_ok);
    sts.scan_end    = !rd_valid_r && ((idx_r >= region_hw_r) || found_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (item_r.op == OP_ADD_REGION) && add_region_ok) begin
      mem[reg_pick] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      mem_q <= mem[idx_r[REG_IDX_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_live_r  <= '0;
      owner_hw_r    <= '0;
      region_live_r <= '0;
      region_hw_r   <= '0;
      idx_r         <= '0;
      rd_valid_r    <= 1'b0;
      found_r       <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (item_r.op)
          OP_ADD_OWNER: begin
            if (own_pick_ok) begin
              owner_live_r[own_pick] <= 1'b1;
              if (OWN_CNT_W'(own_pick) == owner_hw_r) begin
                owner_hw_r <= owner_hw_r + OWN_CNT_W'(1);
              end
            end
          end
          OP_ADD_REGION: begin
            if (add_region_ok) begin
              region_live_r[reg_pick] <= 1'b1;
              if (REG_CNT_W'(reg_pick) == region_hw_r) begin
                region_hw_r <= region_hw_r + REG_CNT_W'(1);
              end
            end
          end
          OP_DEL_REGION: begin
            if (rid_ok) begin
              region_live_r[item_r.region_id] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_init) begin
        idx_r      <= '0;
        rd_valid_r <= 1'b0;
        found_r    <= 1'b0;
      end else begin
        if (issue) begin
          idx_r <= idx_r + REG_CNT_W'(1);
        end
        rd_valid_r <= issue;
        if (hit_now) begin
          found_r <= 1'b1;
        end
      end
      if (owner_match) begin
        region_live_r[rd_idx_r] <= 1'b0;
      end
      if (cmd.finish && (item_r.op == OP_DEL_OWNER)) begin
        owner_live_r[item_r.owner_id] <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (issue) begin
      rd_idx_r <= idx_r[REG_IDX_W-1:0];
    end
    if (cmd.exec) begin
      res_r <= exec_res;
    end
    if (cmd.scan_init) begin
      res_r <= '0;
    end
    if (hit_now) begin
      res_r.found     <= 1'b1;
      res_r.hit_slot  <= SLOT_W'(rd_idx_r);
      res_r.hit_owner <= mem_q.owner;
      res_r.hit_base  <= mem_q.base;
      res_r.hit_size  <= mem_q.size;
      res_r.hit_type  <= mem_q.kind;
      res_r.hit_user  <= mem_q.user;
    end
    if (cmd.finish && (item_r.op == OP_DEL_OWNER) && !owner_live_r[item_r.owner_id]) begin
      res_r.status <= ST_FREE;
    end
  end

  assign out_item = res_r;

endmodule

### design/resource_region_registry_top.sv
// adds, region delete and handle errors go from the check state straight to the result
// owner deletes and find first scan the region slots below n, the region high-water
//   count (up to 32); a find that hits slot k ends its scan early
// a new item can be taken in the result cycle
// reset: synchronous active-low rst_n empties both tables and high-water counts
// the receiver cannot stall: out_valid strobes each result on out_item for one cycle only
module resource_region_registry_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rrr_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rrr_pkg::out_item_t out_item
);
  import rrr_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle, check, region scan, result
  rrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // owner and region tables, slot pickers, scan compare and result register
  rrr_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

### design/rrr_checker.sv
// port-level checker for the resource region registry and its bind
`include "resource_region_registry_top_defines.svh"

module rrr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input rrr_pkg::out_item_t out_item
);
  import rrr_pkg::*;

  logic accept;
  assign accept = start && !busy;

  `RRR_ASSERT_NEXT(a_busy_after_accept, accept, busy)
  `RRR_ASSERT_NEXT(a_no_result_after_accept, accept, !out_valid)
  `RRR_ASSERT_NEXT(a_single_cycle_strobe, out_valid, !out_valid)
  `RRR_ASSERT_NOW(a_status_code, out_valid, out_item.status <= ST_ZERO_ADDR)

endmodule

bind resource_region_registry_top rrr_checker u_rrr_checker (.*);

### tb/tb_resource_region_registry_top.sv
// self-checking testbench for the resource region registry: directed and random commands
`timescale 1ns / 1ps

module tb_resource_region_registry_top;
  import rrr_pkg::*;

  // undefined opcodes, expected to act as a no-op with an all-zero result
  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // shadow copy of the registry, updated in order of command acceptance
  bit            owner_used [OWNER_SLOTS];
  int            owner_hw;
  bit            region_used [REGION_SLOTS];
  region_entry_t region_tab [REGION_SLOTS];
  int            region_hw;

  out_item_t pending_replies [$];
  out_item_t want;
  int        mismatch_cnt;
  int        cycle_cnt;

  resource_region_registry_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // run limit, counted from time zero
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // compute the reply to one command and apply its effect on the shadow tables
  function automatic out_item_t registry_reply(in_item_t cmd);
    out_item_t r;
    int        slot_pick;
    logic [63:0] lim;
    r = '0;
    slot_pick = -1;
    case (cmd.op)
      OP_ADD_OWNER: begin
        // lowest free slot below the high-water count, else append
        for (int i = 0; i < owner_hw; i++)
          if (slot_pick < 0 && !owner_used[i]) slot_pick = i;
        if (slot_pick < 0 && owner_hw < OWNER_SLOTS) slot_pick = owner_hw;
        if (slot_pick < 0) begin
          r.status = ST_FULL;
        end else begin
          owner_used[slot_pick] = 1'b1;
          if (slot_pick == owner_hw) owner_hw++;
          r.slot = SLOT_W'(slot_pick);
        end
      end
      OP_ADD_REGION: begin
        // owner handle is checked before the zero base
        if (cmd.owner_id >= owner_hw) begin
          r.status = ST_BAD_HANDLE;
        end else if (cmd.address == '0) begin
          r.status = ST_ZERO_ADDR;
        end else begin
          for (int i = 0; i < region_hw; i++)
            if (slot_pick < 0 && !region_used[i]) slot_pick = i;
          if (slot_pick < 0 && region_hw < REGION_SLOTS) slot_pick = region_hw;
          if (slot_pick < 0) begin
            r.status = ST_FULL;
          end else begin
            region_used[slot_pick]     = 1'b1;
            region_tab[slot_pick].owner = cmd.owner_id;
            region_tab[slot_pick].base  = cmd.address;
            region_tab[slot_pick].size  = cmd.region_size;
            region_tab[slot_pick].kind  = cmd.region_type;
            region_tab[slot_pick].user  = cmd.user_word;
            if (slot_pick == region_hw) region_hw++;
            r.slot = SLOT_W'(slot_pick);
          end
        end
      end
      OP_DEL_OWNER, OP_DEL_OWNER_REGIONS: begin
        if (cmd.owner_id >= owner_hw) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          // regions go even when the owner itself is already free
          for (int i = 0; i < region_hw; i++)
            if (region_used[i] && region_tab[i].owner == cmd.owner_id) region_used[i] = 1'b0;
          if (cmd.op == OP_DEL_OWNER) begin
            if (!owner_used[cmd.owner_id]) r.status = ST_FREE;
            else owner_used[cmd.owner_id] = 1'b0;
          end
        end
      end
      OP_DEL_REGION: begin
        if (cmd.region_id >= region_hw) r.status = ST_BAD_HANDLE;
        else if (!region_used[cmd.region_id]) r.status = ST_FREE;
        else region_used[cmd.region_id] = 1'b0;
      end
      OP_FIND: begin
        // lowest live region with base <= addr < base + size, end wraps mod 2^64
        for (int i = 0; i < region_hw; i++) begin
          lim = region_tab[i].base + {24'b0, region_tab[i].size};
          if (!r.found && region_used[i] && cmd.address >= region_tab[i].base &&
              cmd.address < lim) begin
            r.found     = 1'b1;
            r.hit_slot  = SLOT_W'(i);
            r.hit_owner = region_tab[i].owner;
            r.hit_base  = region_tab[i].base;
            r.hit_size  = region_tab[i].size;
            r.hit_type  = region_tab[i].kind;
            r.hit_user  = region_tab[i].user;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_u64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [39:0] rand_u40();
    logic [31:0] hi;
    hi = $urandom;
    return {hi[7:0], $urandom};
  endfunction

  // idle cycles before an item: mostly none or short, now and then long
  function automatic int pick_gap(bit no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_cmd(logic [2:0] op, logic [3:0] oid, logic [4:0] rid,
                                        logic [63:0] addr, logic [39:0] size,
                                        logic [31:0] kind, logic [63:0] user);
    in_item_t c;
    c.op          = op;
    c.owner_id    = oid;
    c.region_id   = rid;
    c.address     = addr;
    c.region_size = size;
    c.region_type = kind;
    c.user_word   = user;
    return c;
  endfunction

  // present one item after a gap, hold it until taken, then record its reply
  task automatic send_cmd(in_item_t cmd, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    // busy is read before the edge updates it, so this is the accepting edge
    do @(posedge clk); while (busy);
    pending_replies.push_back(registry_reply(cmd));
  endtask

  // stop sending and wait until every reply is back
  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // compare each strobed reply with the oldest one still pending
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("reply strobed with no command outstanding");
        mismatch_cnt++;
      end else begin
        want = pending_replies.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatch_cnt++;
        end
        if (out_item.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_item.slot);
          mismatch_cnt++;
        end
        if (out_item.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_item.found);
          mismatch_cnt++;
        end
        if (out_item.hit_slot !== want.hit_slot) begin
          $error("hit_slot: expected %0d, got %0d", want.hit_slot, out_item.hit_slot);
          mismatch_cnt++;
        end
        if (out_item.hit_owner !== want.hit_owner) begin
          $error("hit_owner: expected %0d, got %0d", want.hit_owner, out_item.hit_owner);
          mismatch_cnt++;
        end
        if (out_item.hit_base !== want.hit_base) begin
          $error("hit_base: expected %0h, got %0h", want.hit_base, out_item.hit_base);
          mismatch_cnt++;
        end
        if (out_item.hit_size !== want.hit_size) begin
          $error("hit_size: expected %0h, got %0h", want.hit_size, out_item.hit_size);
          mismatch_cnt++;
        end
        if (out_item.hit_type !== want.hit_type) begin
          $error("hit_type: expected %0h, got %0h", want.hit_type, out_item.hit_type);
          mismatch_cnt++;
        end
        if (out_item.hit_user !== want.hit_user) begin
          $error("hit_user: expected %0h, got %0h", want.hit_user, out_item.hit_user);
          mismatch_cnt++;
        end
      end
    end
  end

  // fresh tables: every handle is invalid, find misses, undefined ops do nothing
  task automatic test_empty_tables();
    send_cmd(make_cmd(OP_ADD_REGION, 4'd0, 5'd0, 64'h1000, 40'h10, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_DEL_OWNER, 4'd0, 5'd0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_DEL_OWNER_REGIONS, 4'd15, 5'd31, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_DEL_REGION, 4'd0, 5'd0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_FIND, 4'd0, 5'd0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_UNDEF_LO, '1, '1, '1, '1, '1, '1), pick_gap(0));
    send_cmd(make_cmd(OP_UNDEF_HI, '1, '1, '1, '1, '1, '1), pick_gap(0));
  endtask

  // owners, then regions: handle check before zero base, extreme field values,
  // a region that wraps past the top of the address space and a zero-size one
  task automatic test_adds();
    send_cmd(make_cmd(OP_ADD_OWNER, '0, '0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_ADD_OWNER, '1, '1, '1, '1, '1, '1), pick_gap(0));
    send_cmd(make_cmd(OP_ADD_REGION, 4'd1, 5'd0, 64'h1000, 40'h100, '1, '1), pick_gap(0));
    send_cmd(make_cmd(OP_ADD_REGION, 4'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FF00, 40'h200,
                      32'h0, 64'h0), pick_gap(0));
    send_cmd(make_cmd(OP_ADD_REGION, 4'd0, 5'd0, 64'h2000, 40'h0, 32'h5, 64'h7), pick_gap(0));
    send_cmd(make_cmd(OP_ADD_REGION, 4'd15, 5'd0, 64'h0, 40'h10, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_ADD_REGION, 4'd1, 5'd0, 64'h0, 40'h10, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_ADD_REGION, 4'd0, 5'd0, 64'h1080, '1, 32'hA5A5_5A5A,
                      64'h0123_4567_89AB_CDEF), pick_gap(0));
  endtask

  // probe region edges and the wrapped region's top
  task automatic test_find_edges();
    send_cmd(make_cmd(OP_FIND, '0, '0, 64'h1000, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_FIND, '0, '0, 64'h10FF, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_FIND, '0, '0, 64'h1100, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_FIND, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_FIND, '0, '0, 64'h0FFF, '0, '0, '0), pick_gap(0));
  endtask

  // region and owner deletes, including already free and out-of-range handles
  task automatic test_deletes();
    send_cmd(make_cmd(OP_DEL_REGION, '0, 5'd0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_DEL_REGION, '0, 5'd0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_DEL_REGION, '0, 5'd31, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_DEL_OWNER_REGIONS, 4'd1, '0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_DEL_OWNER, 4'd0, '0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_DEL_OWNER, 4'd0, '0, '0, '0, '0, '0), pick_gap(0));
    send_cmd(make_cmd(OP_ADD_OWNER, '0, '0, '0, '0, '0, '0), pick_gap(0));
  endtask

  // weighted random commands with random noise in the fields an op ignores;
  // handles and probe addresses lean toward ones that hit the tables
  task automatic test_random_mix(int count, int w_own, int w_reg, int w_del_own,
                                 int w_del_regs, int w_del_reg, int w_find, int w_undef,
                                 bit no_gaps);
    in_item_t    cmd;
    int          roll;
    int          pick;
    int          total;
    logic [63:0] base;
    logic [39:0] len;
    total = w_own + w_reg + w_del_own + w_del_regs + w_del_reg + w_find + w_undef;
    repeat (count) begin
      cmd.op          = OP_ADD_OWNER;
      cmd.owner_id    = OWN_IDX_W'($urandom);
      cmd.region_id   = REG_IDX_W'($urandom);
      cmd.address     = rand_u64();
      cmd.region_size = rand_u40();
      cmd.region_type = $urandom;
      cmd.user_word   = rand_u64();
      // valid owner handle most of the time
      if (owner_hw > 0 && $urandom_range(0, 4) != 0)
        cmd.owner_id = OWN_IDX_W'($urandom_range(0, owner_hw - 1));
      roll = $urandom_range(0, total - 1);
      if (roll < w_own) begin
        cmd.op = OP_ADD_OWNER;
      end else if (roll < w_own + w_reg) begin
        cmd.op = OP_ADD_REGION;
        // mostly clustered low bases so regions overlap, some near the top
        case ($urandom_range(0, 9))
          0: cmd.address = rand_u64();
          1: cmd.address = {32'hFFFF_FFFF, $urandom};
          2: cmd.address = '0;
          default: cmd.address = 64'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 9))
          0: cmd.region_size = '0;
          1: cmd.region_size = rand_u40();
          2: cmd.region_size = '1;
          default: cmd.region_size = 40'($urandom_range(1, 4096));
        endcase
      end else if (roll < w_own + w_reg + w_del_own) begin
        cmd.op = OP_DEL_OWNER;
      end else if (roll < w_own + w_reg + w_del_own + w_del_regs) begin
        cmd.op = OP_DEL_OWNER_REGIONS;
      end else if (roll < w_own + w_reg + w_del_own + w_del_regs + w_del_reg) begin
        cmd.op = OP_DEL_REGION;
        if (region_hw > 0 && $urandom_range(0, 4) != 0)
          cmd.region_id = REG_IDX_W'($urandom_range(0, region_hw - 1));
      end else if (roll < total - w_undef) begin
        cmd.op = OP_FIND;
        // aim at a known region's first byte, last byte, end or interior
        if (region_hw > 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, region_hw - 1);
          base = region_tab[pick].base;
          len  = region_tab[pick].size;
          case ($urandom_range(0, 3))
            0: cmd.address = base;
            1: cmd.address = base + {24'b0, len} - 64'd1;
            2: cmd.address = base + {24'b0, len};
            default: cmd.address = (len == '0) ? base : base + (rand_u64() % {24'b0, len});
          endcase
        end else if ($urandom_range(0, 1) == 0) begin
          cmd.address = 64'($urandom_range(0, 70000));
        end
      end else begin
        cmd.op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
      end
      send_cmd(cmd, pick_gap(no_gaps));
    end
  endtask

  // sender holds off until the registry has answered everything, then resumes
  task automatic test_pause_until_quiet();
    test_random_mix(10, 2, 4, 1, 1, 1, 4, 0, 1);
    wait_quiet();
    test_random_mix(10, 2, 4, 1, 1, 1, 4, 0, 1);
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    owner_hw     = 0;
    region_hw    = 0;
    foreach (owner_used[i]) owner_used[i] = 1'b0;
    foreach (region_used[i]) begin
      region_used[i] = 1'b0;
      region_tab[i]  = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_tables();
    test_adds();
    test_find_edges();
    test_deletes();
    wait_quiet();

    // fill both tables past full
    test_random_mix(150, 25, 50, 2, 2, 3, 15, 3, 0);
    wait_quiet();
    // churn: frees and reuse of low slots
    test_random_mix(140, 10, 25, 12, 10, 18, 22, 3, 0);
    test_pause_until_quiet();
    // lookups back to back with no idle cycles
    test_random_mix(140, 5, 20, 3, 3, 8, 60, 1, 1);
    wait_quiet();
    // teardown and refill
    test_random_mix(150, 3, 10, 20, 15, 30, 20, 2, 0);

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
